[sv/table_sorter_defines.svh]
// ----------------------------------------------------------------------------
// table_sorter_defines.svh
// Assertion macros used by the table sorter checker.
// ----------------------------------------------------------------------------
`ifndef TABLE_SORTER_DEFINES_SVH
`define TABLE_SORTER_DEFINES_SVH

// same-cycle implication, off during reset
`define TS_ASSERT_IMP(lbl, clk, rst_n, ant, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
        else $error(msg);

// next-cycle implication, off during reset
`define TS_ASSERT_NXT(lbl, clk, rst_n, ant, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
        else $error(msg);

// next-cycle implication, always on
`define TS_ASSERT_NXT_ALL(lbl, clk, ant, con, msg) \
    lbl: assert property (@(posedge clk) (ant) |=> (con)) else $error(msg);

`endif

[sv/ts_pkg.sv]
// ----------------------------------------------------------------------------
// ts_pkg
// Types and constants of the table sorter.
// ----------------------------------------------------------------------------
package ts_pkg;

    localparam int VALUE_W     = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // one classified element travelling from front to back
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
        logic                      keep;   // element goes into the chain
        logic                      ovf;    // table dropped elements (valid on last)
        logic                      desc;   // direction for this table (valid on last)
    } t_qent;

    typedef enum logic [1:0] {
        S_LOAD = 2'b01,
        S_EMIT = 2'b10
    } t_back_state;

endpackage

[sv/ts_front.sv]
// ----------------------------------------------------------------------------
// ts_front
// Accepts elements, counts the table, flags drops beyond capacity and holds
// the direction register.
// ----------------------------------------------------------------------------
module ts_front import ts_pkg::*; #(
    parameter int CAPACITY = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic                      i_full,
    input  logic signed [VALUE_W-1:0] i_value,
    input  logic                      i_last,
    input  logic                      i_cfg_valid,
    input  logic                      i_cfg_descending,
    output logic                      o_push,
    output t_qent                     o_ent
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0] r_cnt;
    logic          r_ovf;
    logic          r_desc;
    logic          drop;

    assign drop   = (r_cnt == CW'(CAPACITY));
    assign o_push = i_start && !i_full;

    assign o_ent.value = i_value;
    assign o_ent.last  = i_last;
    assign o_ent.keep  = !drop;
    assign o_ent.ovf   = r_ovf || drop;
    assign o_ent.desc  = r_desc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_ovf  <= 1'b0;
            r_desc <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_desc <= i_cfg_descending;
            end
            if (o_push) begin
                if (i_last) begin
                    r_cnt <= '0;
                    r_ovf <= 1'b0;
                end else begin
                    r_cnt <= drop ? r_cnt : r_cnt + CW'(1);
                    r_ovf <= r_ovf || drop;
                end
            end
        end
    end

endmodule

[sv/ts_fifo.sv]
// ----------------------------------------------------------------------------
// ts_fifo
// Short first-word-fall-through queue between front and back.
// ----------------------------------------------------------------------------
module ts_fifo import ts_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_qent i_ent,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_empty,
    output t_qent o_ent
);

    t_qent               r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr;
    logic [QUEUE_AW-1:0] r_rd;
    logic [QUEUE_AW:0]   r_cnt;
    logic                do_push;
    logic                do_pop;

    assign o_full  = (r_cnt == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_ent   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + QUEUE_AW'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + QUEUE_AW'(1);
            end
            unique case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + (QUEUE_AW+1)'(1);
                2'b01:   r_cnt <= r_cnt - (QUEUE_AW+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

[sv/ts_back.sv]
// ----------------------------------------------------------------------------
// ts_back
// Insertion chain: one element enters per cycle in S_LOAD unless the queue
// is empty; cells ascend, and at table end shift out to the low or high end.
// ----------------------------------------------------------------------------
module ts_back import ts_pkg::*; #(
    parameter int CAPACITY = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_empty,
    input  t_qent                     i_ent,
    output logic                      o_pop,
    output logic                      o_strobe,
    output logic signed [VALUE_W-1:0] o_value_res,
    output logic                      o_last_res,
    output logic                      o_overflow
);

    localparam int CW = $clog2(CAPACITY + 1);

    t_back_state               r_state;
    logic signed [VALUE_W-1:0] r_c [CAPACITY];
    logic [CAPACITY-1:0]       r_v;
    logic [CW-1:0]             r_cnt;
    logic [CW-1:0]             r_left;
    logic                      r_desc;
    logic                      r_ovf;
    logic                      r_strobe;
    logic signed [VALUE_W-1:0] r_val;
    logic                      r_lastres;

    logic [CAPACITY-1:0]       lt;
    logic [CAPACITY-1:0]       prv_lt;
    logic [CAPACITY-1:0]       prv_v;
    logic [CAPACITY-1:0]       nxt_v;
    logic signed [VALUE_W-1:0] prv_c [CAPACITY];
    logic signed [VALUE_W-1:0] nxt_c [CAPACITY];
    logic                      ins;
    logic                      emit_vld;
    logic signed [VALUE_W-1:0] emit_val;

    assign o_pop    = (r_state == S_LOAD) && !i_empty;
    assign ins      = o_pop && i_ent.keep;
    assign emit_vld = r_desc ? r_v[CAPACITY-1] : r_v[0];
    assign emit_val = r_desc ? r_c[CAPACITY-1] : r_c[0];

    // empty cells act as +infinity
    genvar g;
    for (g = 0; g < CAPACITY; g++) begin : g_cell
        assign lt[g] = !r_v[g] || (i_ent.value < r_c[g]);
        if (g == 0) begin : g_lo
            assign prv_lt[g] = 1'b0;
            assign prv_v[g]  = 1'b0;
            assign prv_c[g]  = '0;
        end else begin : g_mid
            assign prv_lt[g] = lt[g-1];
            assign prv_v[g]  = r_v[g-1];
            assign prv_c[g]  = r_c[g-1];
        end
        if (g == CAPACITY - 1) begin : g_hi
            assign nxt_v[g] = 1'b0;
            assign nxt_c[g] = '0;
        end else begin : g_top
            assign nxt_v[g] = r_v[g+1];
            assign nxt_c[g] = r_c[g+1];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < CAPACITY; i++) begin
            if (r_state == S_EMIT) begin
                r_c[i] <= r_desc ? prv_c[i] : nxt_c[i];
            end else if (ins && lt[i]) begin
                r_c[i] <= prv_lt[i] ? prv_c[i] : i_ent.value;
            end
        end
        r_val <= emit_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_v       <= '0;
            r_cnt     <= '0;
            r_left    <= '0;
            r_desc    <= 1'b0;
            r_ovf     <= 1'b0;
            r_strobe  <= 1'b0;
            r_lastres <= 1'b0;
        end else begin
            r_strobe  <= 1'b0;
            r_lastres <= 1'b0;
            unique case (r_state)
                S_LOAD: begin
                    if (ins) begin
                        for (int i = 0; i < CAPACITY; i++) begin
                            if (lt[i]) begin
                                r_v[i] <= prv_lt[i] ? prv_v[i] : 1'b1;
                            end
                        end
                    end
                    if (o_pop) begin
                        if (i_ent.last) begin
                            r_left  <= r_cnt + CW'(i_ent.keep);
                            r_cnt   <= '0;
                            r_desc  <= i_ent.desc;
                            r_ovf   <= i_ent.ovf;
                            r_state <= S_EMIT;
                        end else begin
                            r_cnt <= r_cnt + CW'(i_ent.keep);
                        end
                    end
                end
                S_EMIT: begin
                    r_v <= r_desc ? prv_v : nxt_v;
                    if (emit_vld) begin
                        r_strobe  <= 1'b1;
                        r_lastres <= (r_left == CW'(1));
                        r_left    <= r_left - CW'(1);
                        if (r_left == CW'(1)) begin
                            r_state <= S_LOAD;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign o_strobe    = r_strobe;
    assign o_value_res = r_val;
    assign o_last_res  = r_lastres;
    assign o_overflow  = r_ovf;

endmodule

[sv/table_sorter.sv]
// ----------------------------------------------------------------------------
// table_sorter
// Collects a table of signed Q16.16 elements and returns it sorted.
// ----------------------------------------------------------------------------
// Usage:
//   Input: one element per beat on i_value/i_last, taken when i_start is
//   high and o_busy is low. i_last ends the table. Elements past CAPACITY
//   are dropped and the table's results carry o_overflow.
//   Config: i_cfg_descending written when i_cfg_valid is high; o_cfg_ready
//   is always high. Write only while the block is idle.
//   Output: each result is on o_value_res/o_last_res/o_overflow for one
//   cycle with o_strobe; the receiver cannot stall.
// Timing: loading takes one element per cycle while o_busy is low, via a
//   4-entry queue into the insertion chain. During emission the chain takes
//   no elements and sends its results back to back; once the last element
//   has passed the queue the chain enters S_EMIT, and when descending the
//   values first shift up past the empty high cells. o_busy rises while the
//   queue is full, which can happen during emission.
//   Reset empties the queue and chain and sets ascending order.
// ----------------------------------------------------------------------------
module table_sorter import ts_pkg::*; #(
    parameter int CAPACITY = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    output logic                      o_busy,
    input  logic signed [VALUE_W-1:0] i_value,
    input  logic                      i_last,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic                      i_cfg_descending,
    output logic                      o_strobe,
    output logic signed [VALUE_W-1:0] o_value_res,
    output logic                      o_last_res,
    output logic                      o_overflow
);

    logic  push;
    logic  pop;
    logic  full;
    logic  empty;
    t_qent f_ent;
    t_qent q_ent;

    assign o_busy      = full;
    assign o_cfg_ready = 1'b1;

    ts_front #(.CAPACITY(CAPACITY)) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (i_start),
        .i_full           (full),
        .i_value          (i_value),
        .i_last           (i_last),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_descending (i_cfg_descending),
        .o_push           (push),
        .o_ent            (f_ent)
    );

    ts_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_ent   (f_ent),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_ent   (q_ent)
    );

    ts_back #(.CAPACITY(CAPACITY)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_ent       (q_ent),
        .o_pop       (pop),
        .o_strobe    (o_strobe),
        .o_value_res (o_value_res),
        .o_last_res  (o_last_res),
        .o_overflow  (o_overflow)
    );

endmodule

[sv/ts_checker.sv]
// ----------------------------------------------------------------------------
// ts_checker
// Port-level checks of the table sorter result stream.
// ----------------------------------------------------------------------------
`include "table_sorter_defines.svh"

module ts_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_busy,
    input logic o_cfg_ready,
    input logic o_strobe,
    input logic o_last_res,
    input logic o_overflow
);

    `TS_ASSERT_IMP(a_last_strobed, i_clk, i_rst_n, o_last_res, o_strobe, "last without strobe")
    `TS_ASSERT_NXT(a_table_burst, i_clk, i_rst_n, o_strobe && !o_last_res, o_strobe && (o_overflow == $past(o_overflow)), "table results not contiguous or overflow changed")
    `TS_ASSERT_NXT(a_gap_after_last, i_clk, i_rst_n, o_strobe && o_last_res, !o_strobe, "result right after table end")
    `TS_ASSERT_NXT_ALL(a_reset_quiet, i_clk, !i_rst_n, !o_strobe && !o_busy && o_cfg_ready, "outputs not idle after reset")

endmodule

bind table_sorter ts_checker u_ts_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_busy      (o_busy),
    .o_cfg_ready (o_cfg_ready),
    .o_strobe    (o_strobe),
    .o_last_res  (o_last_res),
    .o_overflow  (o_overflow)
);
